[sv/dpw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types, register indexes and helpers for the depth pixel to world
// point projection pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_X_GAIN    = 3'd0;
  localparam logic [2:0] CFG_Y_GAIN    = 3'd1;
  localparam logic [2:0] CFG_Z_GAIN    = 3'd2;
  localparam logic [2:0] CFG_CENTER_U  = 3'd3;
  localparam logic [2:0] CFG_CENTER_V  = 3'd4;
  localparam logic [2:0] CFG_NEAR_RAW  = 3'd5;
  localparam logic [2:0] CFG_FAR_RAW   = 3'd6;

  // Pose word layout: nine rotation words, then three translation words.
  localparam logic [3:0] ROT_WORDS  = 4'd9;
  localparam logic [3:0] POSE_WORDS = 4'd12;

  // Point kinds.
  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_MISS = 1'b1;

  // Three 32-bit words, element 0 first.
  typedef logic [2:0][31:0] vec3_t;

  // Load strobes for the back end stages of one world axis.
  typedef struct packed {
    logic s5;
    logic s6;
    logic s7;
  } row_ld_t;

  // Saturate a signed value to the 32-bit signed range.
  function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[sv/dpw_world_row.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpw_world_row
// One row of the camera-to-world transform: three signed products, an exact
// sum rounded to Q15.16, then the translation and a saturating output.
// ----------------------------------------------------------------------------
module dpw_world_row
  import dpw_pkg::*;
(
  input  wire logic          clk,
  input  wire row_ld_t       ld,
  input  wire vec3_t         rot_row,
  input  wire vec3_t         point,
  input  wire logic [31:0]   trans_word,
  output logic [31:0]        world_r
);

  logic signed [63:0] prod_nxt [3];
  logic signed [63:0] prod_r   [3];
  logic        [31:0] t5_r;
  logic signed [65:0] sum_nxt;
  logic signed [35:0] res6_r;
  logic        [31:0] t6_r;
  logic signed [36:0] world_sum;

  // Stage 5: one 32 by 32 signed multiply per column.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = $signed(rot_row[k]) * $signed(point[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      t5_r <= trans_word;
    end
  end

  // Stage 6: exact sum in Q.46, rounded half up to Q.16 by floor after bias.
  assign sum_nxt = 66'(prod_r[0]) + 66'(prod_r[1]) + 66'(prod_r[2])
                   + 66'sd536870912;

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      res6_r <= sum_nxt[65:30];
      t6_r   <= t5_r;
    end
  end

  // Stage 7: add the translation and saturate into the output register.
  assign world_sum = 37'(res6_r) + 37'($signed(t6_r));

  always_ff @(posedge clk) begin
    if (ld.s7) begin
      world_r <= sat_s32(64'(world_sum));
    end
  end

endmodule
`default_nettype wire

[sv/depth_pixel_to_world_point.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Projects depth-camera pixels into saturated Q15.16 world points.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries either a pixel
//   (in_func = 0: column, row, raw depth) or one pose word (in_func = 1:
//   index and value). The output channel (out_valid / out_ready) carries one
//   point per pixel that is not dropped: kind and world x, y, z.
//   Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
//   write them only while the pipeline is empty. The block does not enforce this.
//   Throughput is one transfer per clock while the receiver keeps out_ready
//   high. The datapath is seven register stages: offsets, the depth
//   multiply, the gain multiply, rounding, the rotation multiply, the row sum
//   and the translation add. A point is offered from the last of them. Pose
//   words travel down the pipeline and take effect at the rotation multiply
//   stage, so they apply exactly to the pixels that follow them.
//   Each stage holds its item while the next stage is full, so a stalled
//   receiver fills bubbles first and in_ready drops only when all stages
//   are occupied. Nothing is lost or repeated.
//   Reset clears the pipeline, the pose to zero, the gains, centers and near
//   limit to zero and the far limit to its maximum.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point
  import dpw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [11:0] in_col,
  input  wire logic [11:0] in_row,
  input  wire logic [15:0] in_raw_depth,
  input  wire logic [3:0]  in_pose_index,
  input  wire logic [31:0] in_pose_value,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_point_kind,
  output logic [31:0]      out_world_x,
  output logic [31:0]      out_world_y,
  output logic [31:0]      out_world_z,
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // Configuration registers.
  logic [31:0] x_gain_r, y_gain_r, z_gain_r;
  logic [15:0] center_u_r, center_v_r, near_raw_r, far_raw_r;

  // Pose storage.
  logic [8:0][31:0] rot_r;
  logic [2:0][31:0] trans_r;

  // Stage valid bits and load enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  // Stage 1 registers and their next values.
  logic        pose1_r, kind1_r, negx1_r, negy1_r;
  logic [15:0] r1_r, magx1_r, magy1_r;
  logic [3:0]  pidx1_r;
  logic [31:0] pval1_r;
  logic        v1_nxt, kind1_nxt, miss1, drop1;
  logic [15:0] r1_nxt, magx1_nxt, magy1_nxt;
  logic signed [17:0] offx1, offy1;

  // Stage 2 registers.
  logic        pose2_r, kind2_r, negx2_r, negy2_r;
  logic [31:0] mx2_r, my2_r;
  logic [47:0] z2_r;
  logic [3:0]  pidx2_r;
  logic [31:0] pval2_r;

  // Stage 3 registers.
  logic        pose3_r, kind3_r, negx3_r, negy3_r;
  logic [63:0] prodx3_r, prody3_r;
  logic [31:0] pz3_r, pz3_nxt;
  logic [48:0] zround3;
  logic [3:0]  pidx3_r;
  logic [31:0] pval3_r;

  // Stage 4 registers.
  logic        pose4_r, kind4_r;
  logic [31:0] px4_r, py4_r, pz4_r, px4_nxt, py4_nxt;
  logic [63:0] roundx4, roundy4;
  logic [43:0] qx4, qy4;
  logic [3:0]  pidx4_r;
  logic [31:0] pval4_r;
  logic        pose_commit;
  logic [1:0]  tidx4;

  // Back end kind bits.
  logic kind5_r, kind6_r, out_kind_r;

  row_ld_t row_ld;
  vec3_t   point4;

  // Stage handshake: a stage loads when it is empty or its item moves on.
  assign en7      = !out_valid_r || out_ready;
  assign en6      = !v6_r || en7;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Configuration writes; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r   <= '0;
      y_gain_r   <= '0;
      z_gain_r   <= '0;
      center_u_r <= '0;
      center_v_r <= '0;
      near_raw_r <= '0;
      far_raw_r  <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_GAIN:   x_gain_r   <= cfg_wdata;
        CFG_Y_GAIN:   y_gain_r   <= cfg_wdata;
        CFG_Z_GAIN:   z_gain_r   <= cfg_wdata;
        CFG_CENTER_U: center_u_r <= cfg_wdata[15:0];
        CFG_CENTER_V: center_v_r <= cfg_wdata[15:0];
        CFG_NEAR_RAW: near_raw_r <= cfg_wdata[15:0];
        CFG_FAR_RAW:  far_raw_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Stage 1: classify the depth and form the centered offsets in Q.4.
  always_comb begin
    miss1     = (in_raw_depth == 16'd0) || (in_raw_depth > far_raw_r);
    drop1     = !miss1 && (in_raw_depth < near_raw_r);
    r1_nxt    = miss1 ? far_raw_r : in_raw_depth;
    kind1_nxt = miss1 ? KIND_MISS : KIND_HIT;
    offx1     = $signed({2'b00, in_col, 4'b0000}) - $signed({2'b00, center_u_r});
    offy1     = $signed({2'b00, in_row, 4'b0000}) - $signed({2'b00, center_v_r});
    magx1_nxt = offx1[17] ? 16'(-offx1) : offx1[15:0];
    magy1_nxt = offy1[17] ? 16'(-offy1) : offy1[15:0];
    if (!in_valid) begin
      v1_nxt = 1'b0;
    end else if (in_func) begin
      v1_nxt = in_pose_index < POSE_WORDS;
    end else begin
      v1_nxt = !drop1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pose1_r <= in_func;
      kind1_r <= kind1_nxt;
      r1_r    <= r1_nxt;
      magx1_r <= magx1_nxt;
      magy1_r <= magy1_nxt;
      negx1_r <= offx1[17];
      negy1_r <= offy1[17];
      pidx1_r <= in_pose_index;
      pval1_r <= in_pose_value;
    end
  end

  // Stage 2: offset magnitudes times the depth, and the z gain times the depth.
  always_ff @(posedge clk) begin
    if (en2) begin
      pose2_r <= pose1_r;
      kind2_r <= kind1_r;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
      mx2_r   <= {16'd0, magx1_r} * {16'd0, r1_r};
      my2_r   <= {16'd0, magy1_r} * {16'd0, r1_r};
      z2_r    <= {32'd0, r1_r} * {16'd0, z_gain_r};
      pidx2_r <= pidx1_r;
      pval2_r <= pval1_r;
    end
  end

  // Stage 3: lateral gains, and z rounded to Q.16 with positive saturation.
  always_comb begin
    zround3 = {1'b0, z2_r} + 49'd32768;
    pz3_nxt = (zround3[48:47] != 2'b00) ? 32'h7FFF_FFFF : zround3[47:16];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pose3_r  <= pose2_r;
      kind3_r  <= kind2_r;
      negx3_r  <= negx2_r;
      negy3_r  <= negy2_r;
      prodx3_r <= {32'd0, mx2_r} * {32'd0, x_gain_r};
      prody3_r <= {32'd0, my2_r} * {32'd0, y_gain_r};
      pz3_r    <= pz3_nxt;
      pidx3_r  <= pidx2_r;
      pval3_r  <= pval2_r;
    end
  end

  // Stage 4: round the magnitudes half away from zero, restore sign, saturate.
  always_comb begin
    roundx4 = prodx3_r + 64'd524288;
    roundy4 = prody3_r + 64'd524288;
    qx4     = roundx4[63:20];
    qy4     = roundy4[63:20];
    px4_nxt = sat_s32(negx3_r ? -$signed({20'd0, qx4}) : $signed({20'd0, qx4}));
    py4_nxt = sat_s32(negy3_r ? -$signed({20'd0, qy4}) : $signed({20'd0, qy4}));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pose4_r <= pose3_r;
      kind4_r <= kind3_r;
      px4_r   <= px4_nxt;
      py4_r   <= py4_nxt;
      pz4_r   <= pz3_r;
      pidx4_r <= pidx3_r;
      pval4_r <= pval3_r;
    end
  end

  // Pose words commit as they leave stage 4, behind all earlier pixels.
  assign pose_commit = v4_r && pose4_r && en5;
  assign tidx4       = 2'(pidx4_r - ROT_WORDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r   <= '0;
      trans_r <= '0;
    end else if (pose_commit) begin
      if (pidx4_r < ROT_WORDS) begin
        rot_r[pidx4_r] <= pval4_r;
      end else begin
        trans_r[tidx4] <= pval4_r;
      end
    end
  end

  // Valid bits; only pixels continue past stage 4.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= v1_nxt;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r && !pose4_r;
      if (en6) v6_r <= v5_r;
      if (en7) out_valid_r <= v6_r;
    end
  end

  // Point kind follows the back end stages.
  always_ff @(posedge clk) begin
    if (en5) kind5_r <= kind4_r;
    if (en6) kind6_r <= kind5_r;
    if (en7) out_kind_r <= kind6_r;
  end

  assign row_ld.s5 = en5;
  assign row_ld.s6 = en6;
  assign row_ld.s7 = en7;
  assign point4    = {pz4_r, py4_r, px4_r};

  // World transform, one row per axis.
  dpw_world_row u_row_x (
    .clk        (clk),
    .ld         (row_ld),
    .rot_row    ({rot_r[2], rot_r[1], rot_r[0]}),
    .point      (point4),
    .trans_word (trans_r[0]),
    .world_r    (out_world_x)
  );

  dpw_world_row u_row_y (
    .clk        (clk),
    .ld         (row_ld),
    .rot_row    ({rot_r[5], rot_r[4], rot_r[3]}),
    .point      (point4),
    .trans_word (trans_r[1]),
    .world_r    (out_world_y)
  );

  dpw_world_row u_row_z (
    .clk        (clk),
    .ld         (row_ld),
    .rot_row    ({rot_r[8], rot_r[7], rot_r[6]}),
    .point      (point4),
    .trans_word (trans_r[2]),
    .world_r    (out_world_z)
  );

  assign out_valid      = out_valid_r;
  assign out_point_kind = out_kind_r;

`ifndef ASSERT_OFF
  // A full pipeline behind a stalled receiver must refuse new transfers.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && v1_r && v2_r && v3_r && v4_r && v5_r && v6_r)
    |-> !in_ready)
    else $error("input accepted while every stage is full and output stalled");

  // A pose word that leaves stage 4 never becomes a point.
  a_pose_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    pose_commit |=> !v5_r)
    else $error("pose word entered the transform stages");

  // A waiting point is not replaced by the one behind it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_world_x)
    && $stable(out_point_kind)))
    else $error("stalled point changed");
`endif

endmodule
`default_nettype wire
